FILE: hdl/ico_pkg.sv
// ============================================================================
// ico_pkg: shared types for the icosphere triangle subdivider
// Holds the input word, result word and vertex types used by the top and midpoint modules.
// ============================================================================
package ico_pkg;

    localparam int COORD_W = 16;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
    } t_tri_in;

    typedef struct packed {
        t_coord out_a_x;
        t_coord out_a_y;
        t_coord out_a_z;
        t_coord out_b_x;
        t_coord out_b_y;
        t_coord out_b_z;
        t_coord out_c_x;
        t_coord out_c_y;
        t_coord out_c_z;
        logic   last_child;
    } t_tri_out;

endpackage

FILE: hdl/ico_sqrt.sv
// ============================================================================
// ico_sqrt: pipelined integer square root
// Restoring root, BITS_PER_STAGE result bits per register stage, valid
// travels with the data and a side payload rides along.
// ============================================================================
module ico_sqrt #(
    parameter int IN_W           = 58,
    parameter int SIDE_W         = 8,
    parameter int BITS_PER_STAGE = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [(IN_W+1)/2-1:0] o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int RW  = (IN_W + 1) / 2;
    localparam int RAD = 2 * RW;
    localparam int NS  = (RW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int REM = RW + 2;

    logic [NS:0]           r_v;
    logic [RAD-1:0]        r_rad  [NS+1];
    logic [REM-1:0]        r_rem  [NS+1];
    logic [RW-1:0]         r_root [NS+1];
    logic [SIDE_W-1:0]     r_side [NS+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rad[0]  = RAD'(i_rad);
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RAD-1:0]    n_rad;
        logic [REM-1:0]    n_rem;
        logic [RW-1:0]     n_root;

        always_comb begin
            logic [REM-1:0] trial;
            n_rad  = r_rad[s];
            n_rem  = r_rem[s];
            n_root = r_root[s];
            trial  = '0;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                if (s * BITS_PER_STAGE + k < RW) begin
                    n_rem = {n_rem[REM-3:0], n_rad[RAD-1 -: 2]};
                    n_rad = {n_rad[RAD-3:0], 2'b00};
                    trial = REM'({n_root, 2'b01});
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[RW-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[RW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_rad[s+1]  <= n_rad;
            r_rem[s+1]  <= n_rem;
            r_root[s+1] <= n_root;
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];
endmodule

FILE: hdl/ico_div.sv
// ============================================================================
// ico_div: pipelined unsigned restoring divider
// Produces QW quotient bits, BITS_PER_STAGE per register stage.
// ============================================================================
module ico_div #(
    parameter int NUM_W          = 40,
    parameter int DEN_W          = 30,
    parameter int QW             = 17,
    parameter int SIDE_W         = 8,
    parameter int BITS_PER_STAGE = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quot,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);
    // quotient bits above QW only flag overflow
    localparam int NS    = (QW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int REM   = DEN_W + 1;
    localparam int SH    = QW;
    localparam int HI    = NUM_W - SH;
    localparam int CMP_W = (HI > DEN_W) ? HI : DEN_W;

    logic [NS:0]       r_v;
    logic [SH-1:0]     r_num  [NS+1];
    logic [REM-1:0]    r_rem  [NS+1];
    logic [QW-1:0]     r_q    [NS+1];
    logic [DEN_W-1:0]  r_den  [NS+1];
    logic [NS:0]       r_ovf;
    logic [SIDE_W-1:0] r_side [NS+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_num[0]  = i_num[SH-1:0];
        // high part: overflow if it already reaches the divisor
        r_ovf[0]  = (CMP_W'(i_num[NUM_W-1:SH]) >= CMP_W'(i_den));
        r_rem[0]  = REM'(i_num[NUM_W-1:SH]);
        r_q[0]    = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [SH-1:0]  n_num;
        logic [REM-1:0] n_rem;
        logic [QW-1:0]  n_q;

        always_comb begin
            n_num = r_num[s];
            n_rem = r_rem[s];
            n_q   = r_q[s];
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                if (s * BITS_PER_STAGE + k < QW) begin
                    n_rem = {n_rem[REM-2:0], n_num[SH-1]};
                    n_num = {n_num[SH-2:0], 1'b0};
                    if (n_rem >= REM'(r_den[s])) begin
                        n_rem = n_rem - REM'(r_den[s]);
                        n_q   = {n_q[QW-2:0], 1'b1};
                    end else begin
                        n_q   = {n_q[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_num[s+1]  <= n_num;
            r_rem[s+1]  <= n_rem;
            r_q[s+1]    <= n_q;
            r_den[s+1]  <= r_den[s];
            r_ovf[s+1]  <= r_ovf[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_v[NS];
    assign o_quot  = r_q[NS];
    assign o_ovf   = r_ovf[NS];
    assign o_side  = r_side[NS];
endmodule

FILE: hdl/ico_unit_mid.sv
// ============================================================================
// ico_unit_mid: edge midpoint scaled to unit length
// Sum, squared norm, square root, then three rounded divisions with
// saturation. One edge per cycle, fixed latency.
// ============================================================================
module ico_unit_mid #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ico_pkg::t_vec i_a,
    input  ico_pkg::t_vec i_b,
    output logic          o_valid,
    output ico_pkg::t_vec o_m
);
    localparam int MAG_W = 16;                  // |a+b| up to 65536 fits 17
    localparam int SQ_W  = 2 * (MAG_W + 1);
    localparam int N_W   = SQ_W + 2;
    localparam int RAD_W = N_W + 20;
    localparam int L_W   = (RAD_W + 1) / 2;
    localparam int NUM_W = MAG_W + 1 + COORD_FRAC_BITS + 11;
    localparam int DEN_W = L_W + 1;
    localparam int QW    = 17;
    localparam int SIDE  = 3 * (MAG_W + 1) + 3 + 1;

    // stage 1: sums and magnitudes
    logic [MAG_W:0] r_mag [3];
    logic [2:0]     r_neg;
    logic           r_v1;
    always_ff @(posedge i_clk) begin
        logic signed [MAG_W:0] s [3];
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        s[0] = 17'(i_a.x) + 17'(i_b.x);
        s[1] = 17'(i_a.y) + 17'(i_b.y);
        s[2] = 17'(i_a.z) + 17'(i_b.z);
        for (int i = 0; i < 3; i++) begin
            r_neg[i] <= s[i][MAG_W];
            r_mag[i] <= s[i][MAG_W] ? 17'(-s[i]) : 17'(s[i]);
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0] r_sq [3];
    logic [MAG_W:0]  r_mag2 [3];
    logic [2:0]      r_neg2;
    logic            r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        for (int i = 0; i < 3; i++) begin
            r_sq[i]   <= r_mag[i] * r_mag[i];
            r_mag2[i] <= r_mag[i];
        end
        r_neg2 <= r_neg;
    end

    // stage 3: norm
    logic [N_W-1:0] r_n;
    logic [MAG_W:0] r_mag3 [3];
    logic [2:0]     r_neg3;
    logic           r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_n    <= N_W'(r_sq[0]) + N_W'(r_sq[1]) + N_W'(r_sq[2]);
        r_mag3 <= r_mag2;
        r_neg3 <= r_neg2;
    end

    logic [SIDE-1:0] sq_side_in, sq_side_out;
    logic            sq_v;
    logic [L_W-1:0]  sq_root;
    assign sq_side_in = {r_mag3[0], r_mag3[1], r_mag3[2], r_neg3, (r_n == '0)};

    ico_sqrt #(.IN_W(RAD_W), .SIDE_W(SIDE), .BITS_PER_STAGE(4)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   ({r_n, 20'd0}),
        .i_side  (sq_side_in),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side_out)
    );

    logic [MAG_W:0] mag_l [3];
    logic [2:0]     neg_l;
    logic           zero_l;
    assign {mag_l[0], mag_l[1], mag_l[2], neg_l, zero_l} = sq_side_out;

    logic [2:0]  dv_v;
    logic [QW-1:0] dq [3];
    logic [2:0]  dovf;
    logic [1:0]  dside [3];
    // zero length: force a nonzero divisor, result is masked
    logic [DEN_W-1:0] den;
    assign den = zero_l ? DEN_W'(2) : {sq_root, 1'b0};

    for (genvar i = 0; i < 3; i++) begin : g_div
        ico_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QW), .SIDE_W(2),
                  .BITS_PER_STAGE(3)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v),
            .i_num   (NUM_W'({mag_l[i], {(COORD_FRAC_BITS + 11){1'b0}}})
                      + NUM_W'(sq_root)),
            .i_den   (den),
            .i_side  ({neg_l[i], zero_l}),
            .o_valid (dv_v[i]),
            .o_quot  (dq[i]),
            .o_ovf   (dovf[i]),
            .o_side  (dside[i])
        );
    end

    logic signed [ico_pkg::COORD_W-1:0] comp [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dside[i][0]) begin
                comp[i] = '0;
            end else if (dside[i][1]) begin
                comp[i] = (dovf[i] || dq[i] > 17'd32768) ? 16'sh8000 : 16'(-dq[i]);
            end else begin
                comp[i] = (dovf[i] || dq[i] > 17'd32767) ? 16'sh7fff : 16'(dq[i]);
            end
        end
    end

    assign o_valid = &dv_v;
    assign o_m     = '{x: comp[0], y: comp[1], z: comp[2]};
endmodule

FILE: hdl/icosphere_triangle_subdivider_top.sv
// ============================================================================
// icosphere_triangle_subdivider_top: one level of icosphere subdivision
// Splits a triangle into four children with unit-length edge midpoints.
// ============================================================================
// usage:
//   input word: pulse start with a triangle on i_tri while busy is low;
//   it is taken at that edge. busy then stays high while a gap counter
//   runs down, and no new triangle is taken until it falls.
//   result words: o_strobe marks one child triangle on o_tri for a single
//   cycle; four come back to back per input, the fourth with last_child set.
//   datapath: the three midpoints run in parallel through a fixed pipeline
//   (sum, square, norm, 7 root stages, 6 divide stages), then one sequencer
//   register that sends the four children out back to back.
//   throughput: set by the single result port moving one child per cycle.
//   reset: synchronous, active low; all valid bits clear, nothing in flight.
//   the receiver cannot stall: every result word is taken in its cycle.
module icosphere_triangle_subdivider_top #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ico_pkg::t_tri_in  i_tri,
    output logic              o_strobe,
    output ico_pkg::t_tri_out o_tri
);
    // cycles from take to midpoint valid
    localparam int MID_LAT = 16;

    ico_pkg::t_vec p0, p1, p2;
    assign p0 = '{x: i_tri.a_x, y: i_tri.a_y, z: i_tri.a_z};
    assign p1 = '{x: i_tri.b_x, y: i_tri.b_y, z: i_tri.b_z};
    assign p2 = '{x: i_tri.c_x, y: i_tri.c_y, z: i_tri.c_z};

    logic take;
    logic [1:0] r_gap;
    assign busy = (r_gap != 2'd0);
    assign take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (take) begin
            r_gap <= 2'd3;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    logic [2:0] mv;
    ico_pkg::t_vec m [3];

    ico_unit_mid #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_m0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(take),
        .i_a(p0), .i_b(p1), .o_valid(mv[0]), .o_m(m[0]));
    ico_unit_mid #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_m1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(take),
        .i_a(p1), .i_b(p2), .o_valid(mv[1]), .o_m(m[1]));
    ico_unit_mid #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_m2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(take),
        .i_a(p2), .i_b(p0), .o_valid(mv[2]), .o_m(m[2]));

    // corners ride a delay line matched to the midpoint pipeline
    ico_pkg::t_tri_in r_dl [MID_LAT];
    always_ff @(posedge i_clk) begin
        r_dl[0] <= i_tri;
        for (int k = 1; k < MID_LAT; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    // result sequencer: four children per finished set
    ico_pkg::t_vec r_m [3];
    ico_pkg::t_vec r_p [3];
    logic [1:0] r_k;
    logic       r_act;
    ico_pkg::t_tri_in hold_c;
    assign hold_c = r_dl[MID_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= 2'd0;
        end else if (mv[0]) begin
            r_act <= 1'b1;
            r_k   <= 2'd0;
        end else if (r_act) begin
            r_k   <= r_k + 2'd1;
            r_act <= (r_k != 2'd3);
        end
        if (mv[0]) begin
            r_m[0] <= m[0];
            r_m[1] <= m[1];
            r_m[2] <= m[2];
            r_p[0] <= '{x: hold_c.a_x, y: hold_c.a_y, z: hold_c.a_z};
            r_p[1] <= '{x: hold_c.b_x, y: hold_c.b_y, z: hold_c.b_z};
            r_p[2] <= '{x: hold_c.c_x, y: hold_c.c_y, z: hold_c.c_z};
        end
    end

    ico_pkg::t_vec va, vb, vc;
    always_comb begin
        unique case (r_k)
            2'd0: begin va = r_p[0]; vb = r_m[0]; vc = r_m[2]; end
            2'd1: begin va = r_p[1]; vb = r_m[1]; vc = r_m[0]; end
            2'd2: begin va = r_p[2]; vb = r_m[2]; vc = r_m[1]; end
            default: begin va = r_m[0]; vb = r_m[1]; vc = r_m[2]; end
        endcase
    end

    assign o_strobe = r_act;
    assign o_tri = '{out_a_x: va.x, out_a_y: va.y, out_a_z: va.z,
                     out_b_x: vb.x, out_b_y: vb.y, out_b_z: vb.z,
                     out_c_x: vc.x, out_c_y: vc.y, out_c_z: vc.z,
                     last_child: (r_k == 2'd3)};

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> busy) else $error("accept without gap");
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv[0] == mv[1] && mv[1] == mv[2]) else $error("midpoint lanes skewed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_tri.last_child && !mv[0]) |=> !o_strobe)
        else $error("strobe after last child");
    a_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv[0] |=> o_strobe && !o_tri.last_child) else $error("set not started");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##MID_LAT mv[0]) else $error("midpoint latency off");
endmodule
